### sv/ppts_pkg.sv
// shared types and constants of the priority process table scheduler
package ppts_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int ID_BITS     = 16;
   localparam int TIME_BITS   = 32;
   localparam int MAX_RESULTS = 16;

   localparam logic [2:0] PRIO_LOW  = 3'd1;
   localparam logic [2:0] PRIO_HIGH = 3'd5;

   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_EXECUTE = 2'd1;
   localparam logic [1:0] CMD_EXTRACT = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]           command;
      logic [2:0]           priority_req;
      logic [ID_BITS-1:0]   proc_id;
      logic [TIME_BITS-1:0] amount;
      logic [7:0]           processors;
   } req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [2:0]           out_priority;
      logic [ID_BITS-1:0]   out_id;
      logic [TIME_BITS-1:0] out_time;
      logic [7:0]           unused_processors;
      logic                 last;
   } rsp_word_type;

endpackage

### sv/priority_process_table_scheduler_core.sv
// priority process table scheduler: ordered process table walked by a small sequencer
//
//  channel | ports                          | handshake
//  req     | req_word, start, busy          | taken when start && !busy
//  rsp     | rsp_word, rsp_valid            | each word valid for a single cycle, no back-pressure
//  csr     | csr_we, csr_wdata              | time granule written when csr_we
//
// a command walks the table one entry per cycle, comparing, adding and subtracting
// on the entry at the walk index; a remove or insert shifts one entry per cycle.
// insert and execute first compute a subtract-per-cycle granule remainder;
// the final word is valid in the cycle in which busy falls.
// reset (synchronous) empties the table and sets the granule to one.
module priority_process_table_scheduler_core import ppts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_word_type req_word,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MOD   = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_INSCN = 4'd3;
   localparam logic [3:0] S_INSSH = 4'd4;
   localparam logic [3:0] S_EXEC  = 4'd5;
   localparam logic [3:0] S_RMSH  = 4'd6;
   localparam logic [3:0] S_EXSCN = 4'd7;
   localparam logic [3:0] S_EXEMT = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   logic [2:0]           prio_mem [TABLE_DEPTH];
   logic [ID_BITS-1:0]   id_mem   [TABLE_DEPTH];
   logic [TIME_BITS-1:0] time_mem [TABLE_DEPTH];

   logic [3:0]           state_ff, state_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  ptr_ff, ptr_in;
   logic [7:0]           granule_ff;
   req_word_type         req_ff;
   logic [7:0]           left_ff, left_in;
   logic [5:0]           nout_ff, nout_in;
   logic [TIME_BITS:0]   rem_ff, rem_in;
   logic [5:0]           mstep_ff, mstep_in;
   logic                 rmret_ff, rmret_in;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 rspv_ff, rspv_in;

   // table write port, one entry per cycle
   logic                 we;
   logic [IDX_BITS-1:0]  waddr;
   logic [2:0]           wprio;
   logic [ID_BITS-1:0]   wid;
   logic [TIME_BITS-1:0] wtime;

   logic [IDX_BITS-1:0]  ia, pa;
   logic [2:0]           cur_p;
   logic [ID_BITS-1:0]   cur_id;
   logic [TIME_BITS-1:0] cur_t;
   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS+7:0] gshift;
   logic                 prio_ok;

   assign ia      = idx_ff[IDX_BITS-1:0];
   assign pa      = ptr_ff[IDX_BITS-1:0];
   assign cur_p   = prio_mem[ia];
   assign cur_id  = id_mem[ia];
   assign cur_t   = time_mem[ia];
   assign sum     = {1'b0, cur_t} + {1'b0, req_ff.amount};
   assign prio_ok = req_ff.priority_req >= PRIO_LOW && req_ff.priority_req <= PRIO_HIGH;
   // granule shifted for the restoring remainder step
   assign gshift  = {{TIME_BITS{1'b0}}, (granule_ff == 8'd0 ? 8'd1 : granule_ff)}
                    << (6'd32 - mstep_ff);

   function automatic rsp_word_type mk(input logic [1:0] st, input logic [7:0] un);
      rsp_word_type r;
      r = '0;
      r.status = st;
      r.unused_processors = un;
      r.last = 1'b1;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      ptr_in   = ptr_ff;
      left_in  = left_ff;
      nout_in  = nout_ff;
      rem_in   = rem_ff;
      mstep_in = mstep_ff;
      rmret_in = rmret_ff;
      rsp_in   = rsp_ff;
      rspv_in  = 1'b0;
      we       = 1'b0;
      waddr    = pa;
      wprio    = prio_mem[pa];
      wid      = id_mem[pa];
      wtime    = time_mem[pa];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rem_in   = {1'b0, req_word.amount};
               mstep_in = '0;
               idx_in   = '0;
               left_in  = req_word.processors;
               nout_in  = '0;
               if (req_word.command == CMD_CLEAR) begin
                  count_in = '0;
                  rsp_in   = mk(ST_DONE, 8'd0);
                  state_in = S_RESP;
               end else begin
                  state_in = (req_word.command == CMD_EXTRACT) ? S_DISP : S_MOD;
               end
            end
         end
         S_MOD: begin
            // one restoring remainder step per cycle
            if ({7'd0, rem_ff} >= gshift) rem_in = rem_ff - gshift[TIME_BITS:0];
            mstep_in = mstep_ff + 6'd1;
            if (mstep_ff == 6'd32) state_in = S_DISP;
         end
         S_DISP: begin
            if (req_ff.command == CMD_INSERT) begin
               if (req_ff.amount == '0 || !prio_ok || rem_ff != '0) begin
                  rsp_in = mk(ST_REJECT, 8'd0);
                  state_in = S_RESP;
               end else state_in = S_INSCN;
            end else if (req_ff.command == CMD_EXECUTE) begin
               if (req_ff.amount == '0 || rem_ff != '0) begin
                  rsp_in = mk(ST_REJECT, req_ff.processors);
                  state_in = S_RESP;
               end else if (count_ff == '0) begin
                  rsp_in = mk(ST_NONE, req_ff.processors);
                  state_in = S_RESP;
               end else state_in = S_EXEC;
            end else begin
               if (!prio_ok) begin
                  rsp_in = mk(ST_REJECT, 8'd0);
                  state_in = S_RESP;
               end else state_in = S_EXSCN;
            end
         end
         S_INSCN: begin
            if (idx_ff < count_ff && cur_p >= req_ff.priority_req) begin
               if (cur_p == req_ff.priority_req && cur_id == req_ff.proc_id) begin
                  we    = 1'b1;
                  waddr = ia;
                  wprio = cur_p;
                  wid   = cur_id;
                  if (sum[TIME_BITS]) begin
                     wtime  = '1;
                     rsp_in = mk(ST_FULL, 8'd0);
                  end else begin
                     wtime  = sum[TIME_BITS-1:0];
                     rsp_in = mk(ST_DONE, 8'd0);
                  end
                  state_in = S_RESP;
               end else idx_in = idx_ff + 1'b1;
            end else if (count_ff == CNT_BITS'(TABLE_DEPTH)) begin
               rsp_in = mk(ST_FULL, 8'd0);
               state_in = S_RESP;
            end else begin
               ptr_in   = count_ff;
               state_in = S_INSSH;
            end
         end
         S_INSSH: begin
            // open a gap by moving entries up, then fill it
            we = 1'b1;
            if (ptr_ff == idx_ff) begin
               wprio    = req_ff.priority_req;
               wid      = req_ff.proc_id;
               wtime    = req_ff.amount;
               count_in = count_ff + 1'b1;
               rsp_in   = mk(ST_DONE, 8'd0);
               state_in = S_RESP;
            end else begin
               wprio  = prio_mem[pa - 1'b1];
               wid    = id_mem[pa - 1'b1];
               wtime  = time_mem[pa - 1'b1];
               ptr_in = ptr_ff - 1'b1;
            end
         end
         S_EXEC: begin
            if (left_ff != 8'd0 && idx_ff < count_ff) begin
               left_in = left_ff - 8'd1;
               if (cur_t > req_ff.amount) begin
                  we    = 1'b1;
                  waddr = ia;
                  wprio = cur_p;
                  wid   = cur_id;
                  wtime = cur_t - req_ff.amount;
                  idx_in = idx_ff + 1'b1;
               end else begin
                  ptr_in   = idx_ff;
                  rmret_in = 1'b0;
                  state_in = S_RMSH;
               end
            end else begin
               rsp_in = mk(ST_DONE, left_in);
               state_in = S_RESP;
            end
         end
         S_RMSH: begin
            // close the gap one entry per cycle
            if (ptr_ff + 1'b1 < count_ff) begin
               we     = 1'b1;
               wprio  = prio_mem[pa + 1'b1];
               wid    = id_mem[pa + 1'b1];
               wtime  = time_mem[pa + 1'b1];
               ptr_in = ptr_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = rmret_ff ? S_EXEMT : S_EXEC;
            end
         end
         S_EXSCN: begin
            if (idx_ff < count_ff && cur_p > req_ff.priority_req) idx_in = idx_ff + 1'b1;
            else state_in = S_EXEMT;
         end
         S_EXEMT: begin
            if (nout_ff != 6'(MAX_RESULTS) && idx_ff < count_ff
                && cur_p == req_ff.priority_req) begin
               rsp_in              = '0;
               rsp_in.out_priority = cur_p;
               rsp_in.out_id       = cur_id;
               rsp_in.out_time     = cur_t;
               rspv_in  = 1'b1;
               nout_in  = nout_ff + 6'd1;
               ptr_in   = idx_ff;
               rmret_in = 1'b1;
               state_in = S_RMSH;
            end else if (nout_ff == '0) begin
               rsp_in = mk(ST_NONE, 8'd0);
               state_in = S_RESP;
            end else begin
               // final held word goes out with last set
               rsp_in.last = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rspv_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // held extract words are emitted one slot late so the final carries last
   rsp_word_type hold_ff;
   logic         holdv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         granule_ff <= 8'd1;
         rspv_ff    <= 1'b0;
         holdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) granule_ff <= csr_wdata;
         rspv_ff  <= rspv_in && (state_ff != S_EXEMT || holdv_ff);
         if (rspv_in && state_ff == S_EXEMT) holdv_ff <= 1'b1;
         else if (rspv_in && state_ff == S_RESP) holdv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_word;
      idx_ff   <= idx_in;
      ptr_ff   <= ptr_in;
      left_ff  <= left_in;
      nout_ff  <= nout_in;
      rem_ff   <= rem_in;
      mstep_ff <= mstep_in;
      rmret_ff <= rmret_in;
      if (state_ff == S_EXEMT && rspv_in) begin
         rsp_ff   <= hold_ff;
         hold_ff  <= rsp_in;
      end else if (state_ff == S_EXEMT && state_in == S_RESP && nout_ff != '0) begin
         rsp_ff <= {hold_ff[$bits(rsp_word_type)-1:1], 1'b1};
      end else begin
         rsp_ff <= rsp_in;
      end
      if (we) begin
         prio_mem[waddr] <= wprio;
         id_mem[waddr]   <= wid;
         time_mem[waddr] <= wtime;
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rspv_ff;
   assign rsp_word  = rsp_ff;

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH)) else $error("table count overflow");
   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("command taken without going busy");
   a_gran: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOD |-> mstep_ff <= 6'd32) else $error("remainder step overrun");

endmodule
